// ===== rtl/joystick_differential_drive_mix_defines.svh =====
// assertion macros for the joystick mixer checker
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIX_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JDDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JDDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jddm_pkg.sv =====
// shared types, register codes and sine table function for the joystick mixer
package jddm_pkg;

	typedef struct packed {
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_target;
		logic signed [15:0] right_target;
		logic               motion_active;
	} out_item_t;

	typedef struct packed {
		logic [11:0] forward_max_speed;
		logic [11:0] reverse_max_speed;
		logic [11:0] turn_max_speed;
		logic [15:0] rpm_gain;
		logic [6:0]  dead_zone_radius;
		logic [6:0]  stick_radius;
	} cfg_t;

	// classified sample as it travels from front to back
	typedef struct packed {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic [14:0]       xsq;
		logic [14:0]       ysq;
		logic              zero;
		logic              active;
		logic              pull;
	} job_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FWD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REV  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAD  = 3'd5;

	localparam logic [15:0] TARGET_LIMIT = 16'd25600;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint SC1  = 64'sd1686629713;
	localparam longint SC3  = 64'sd693598668;
	localparam longint SC5  = 64'sd85569306;
	localparam longint SC7  = 64'sd5026997;
	localparam longint SC9  = 64'sd172272;
	localparam longint SC11 = 64'sd3864;

	// q15 quarter-wave sine entry k of a table with 2^bits steps
	function automatic logic [15:0] sine_q15(input int k, input int bits);
		longint t;
		longint t2;
		longint acc;
		t   = longint'(k) <<< (30 - bits);
		t2  = (t * t) >>> 30;
		acc = -SC11;
		acc = ((acc * t2) >>> 30) + SC9;
		acc = ((acc * t2) >>> 30) - SC7;
		acc = ((acc * t2) >>> 30) + SC5;
		acc = ((acc * t2) >>> 30) - SC3;
		acc = ((acc * t2) >>> 30) + SC1;
		acc = (acc * t) >>> 30;
		if (acc < 0)
			acc = 0;
		if (acc > Q30_ONE)
			acc = Q30_ONE;
		return 16'((acc + 64'sd16384) >>> 15);
	endfunction

endpackage

// ===== rtl/jddm_front.sv =====
// front end: dead-zone, zero-radius and pull-onto-circle classification
module jddm_front (
	input  jddm_pkg::cfg_t     cfg,
	input  jddm_pkg::in_item_t sample,
	output jddm_pkg::job_t     job
);
	import jddm_pkg::*;

	logic signed [15:0] xsq_s;
	logic signed [15:0] ysq_s;
	logic [15:0]        r2;
	logic [13:0]        dz2;
	logic [13:0]        rr2;
	logic               dead;

	assign xsq_s = sample.stick_x * sample.stick_x;
	assign ysq_s = sample.stick_y * sample.stick_y;
	assign r2    = 16'(xsq_s) + 16'(ysq_s);
	assign dz2   = cfg.dead_zone_radius * cfg.dead_zone_radius;
	assign rr2   = cfg.stick_radius * cfg.stick_radius;
	assign dead  = r2 < {2'b00, dz2};

	always_comb begin
		job.x      = sample.stick_x;
		job.y      = sample.stick_y;
		job.xsq    = xsq_s[14:0];
		job.ysq    = ysq_s[14:0];
		job.active = !dead;
		job.zero   = dead || (cfg.stick_radius == '0);
		job.pull   = r2 > {2'b00, rr2};
	end
endmodule

// ===== rtl/jddm_queue.sv =====
// two-entry queue of classified samples between front and back
module jddm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jddm_pkg::job_t wdata,
	input  logic           pop,
	output jddm_pkg::job_t rdata,
	output logic           valid,
	output logic           full
);
	import jddm_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign rdata = mem_q[rd_q];
	assign valid = cnt_q != 2'd0;
	assign full  = cnt_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end
endmodule

// ===== rtl/jddm_back.sv =====
// back end: sequencer over a shared restoring divider, square root, sine rom and multipliers
module jddm_back #(
	parameter int SINE_TABLE_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jddm_pkg::cfg_t      cfg,
	input  jddm_pkg::job_t      head,
	input  logic                head_valid,
	output logic                pop,
	output jddm_pkg::out_item_t result,
	output logic                done
);
	import jddm_pkg::*;

	localparam int KW    = SINE_TABLE_BITS + 1;
	localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PLOAD, ST_PDIV, ST_PSQRT, ST_KLOAD, ST_KDIV, ST_ROM, ST_MUL,
		ST_SUM, ST_GLO, ST_GHI, ST_FLOAD, ST_FDIV, ST_FIN
	} state_t;

	logic [15:0] rom_w [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom_w[g] = sine_q15(g, SINE_TABLE_BITS);
	end

	state_t            state_q;
	logic              side_q;
	job_t              job_q;
	logic signed [7:0] ax_q;
	logic signed [7:0] ay_q;
	logic [52:0]       rem_q;
	logic [52:0]       dsr_q;
	logic [15:0]       quo_q;
	logic [3:0]        cnt_q;
	logic [13:0]       sqv_q;
	logic [6:0]        sres_q;
	logic [KW-1:0]     k_q;
	logic [15:0]       romv_q;
	logic [18:0]       p1_q;
	logic signed [35:0] term_x_q;
	logic signed [35:0] term_y_q;
	logic [34:0]       smag_q;
	logic              sneg_q;
	logic [33:0]       plo_q;
	logic [32:0]       phi_q;
	logic              ovf_q;
	logic signed [15:0] left_q;
	logic [13:0]       rsq_q;
	out_item_t         result_q;
	logic              done_q;

	logic signed [7:0] cur_a;
	logic [7:0]        abs8;
	logic [6:0]        m7;
	logic              ge;
	logic [52:0]       rem_sub;
	logic [15:0]       quo_nx;
	logic [6:0]        trial;
	logic [13:0]       trial_sq;
	logic [6:0]        sres_nx;
	logic signed [7:0] pulled;
	logic [11:0]       maxv;
	logic [34:0]       prod;
	logic signed [35:0] term;
	logic [14:0]       asq;
	logic [28:0]       pnum;
	logic signed [36:0] sum;
	logic [52:0]       fl_n;
	logic              fl_ov;
	logic [15:0]       qc;
	logic signed [15:0] fin_val;

	assign cur_a    = side_q ? ay_q : ax_q;
	assign abs8     = cur_a[7] ? 8'(-cur_a) : 8'(cur_a);
	assign m7       = abs8[6:0];
	assign ge       = rem_q >= dsr_q;
	assign rem_sub  = rem_q - dsr_q;
	assign quo_nx   = {quo_q[14:0], ge};
	assign trial    = sres_q | (7'd1 << cnt_q[2:0]);
	assign trial_sq = trial * trial;
	assign sres_nx  = (trial_sq <= sqv_q) ? trial : sres_q;
	assign pulled   = cur_a[7] ? -$signed({1'b0, sres_nx}) : $signed({1'b0, sres_nx});
	// line uses forward when the negated y is positive
	assign maxv     = side_q ? (ay_q[7] ? cfg.forward_max_speed : cfg.reverse_max_speed)
	                         : cfg.turn_max_speed;
	assign prod     = p1_q * romv_q;
	assign term     = (!cur_a[7] && cur_a != 8'sd0) ? -$signed({1'b0, prod})
	                                                 : $signed({1'b0, prod});
	assign asq      = side_q ? job_q.ysq : job_q.xsq;
	assign pnum     = asq * rsq_q;
	assign sum      = side_q ? ({term_y_q[35], term_y_q} - {term_x_q[35], term_x_q})
	                         : ({term_y_q[35], term_y_q} + {term_x_q[35], term_x_q});
	// rounding half of the divisor folded in before the divide
	assign fl_n     = 53'(plo_q) + (53'(phi_q) << 18) + (53'(cfg.stick_radius) << 22);
	assign fl_ov    = fl_n >= (53'(cfg.stick_radius) << 39);
	assign qc       = (ovf_q || quo_q > TARGET_LIMIT) ? TARGET_LIMIT : quo_q;
	assign fin_val  = sneg_q ? -$signed(qc) : $signed(qc);

	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign result = result_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			side_q   <= 1'b0;
			job_q    <= '0;
			ax_q     <= '0;
			ay_q     <= '0;
			rem_q    <= '0;
			dsr_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			sqv_q    <= '0;
			sres_q   <= '0;
			k_q      <= '0;
			romv_q   <= '0;
			p1_q     <= '0;
			term_x_q <= '0;
			term_y_q <= '0;
			smag_q   <= '0;
			sneg_q   <= 1'b0;
			plo_q    <= '0;
			phi_q    <= '0;
			ovf_q    <= 1'b0;
			left_q   <= '0;
			rsq_q    <= '0;
			result_q <= '0;
			done_q   <= 1'b0;
		end else begin
			rsq_q  <= cfg.stick_radius * cfg.stick_radius;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						job_q  <= head;
						ax_q   <= head.x;
						ay_q   <= head.y;
						side_q <= 1'b0;
						if (head.zero) begin
							result_q <= '{left_target: '0, right_target: '0,
							              motion_active: head.active};
							done_q   <= 1'b1;
						end else if (head.pull) begin
							state_q <= ST_PLOAD;
						end else begin
							state_q <= ST_KLOAD;
						end
					end
				end
				ST_PLOAD: begin
					rem_q   <= 53'(pnum);
					dsr_q   <= 53'({job_q.xsq, 1'b0} + {job_q.ysq, 1'b0}) << 14;
					quo_q   <= '0;
					cnt_q   <= 4'd15;
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					if (ge)
						rem_q <= rem_sub;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						sqv_q   <= quo_nx[13:0];
						sres_q  <= '0;
						cnt_q   <= 4'd6;
						state_q <= ST_PSQRT;
					end
				end
				ST_PSQRT: begin
					sres_q <= sres_nx;
					cnt_q  <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						if (!side_q) begin
							ax_q    <= pulled;
							side_q  <= 1'b1;
							state_q <= ST_PLOAD;
						end else begin
							ay_q    <= pulled;
							side_q  <= 1'b0;
							state_q <= ST_KLOAD;
						end
					end
				end
				ST_KLOAD: begin
					rem_q   <= (53'(m7) << KW) + 53'(cfg.stick_radius);
					dsr_q   <= 53'({cfg.stick_radius, 1'b0}) << 15;
					quo_q   <= '0;
					cnt_q   <= 4'd15;
					state_q <= ST_KDIV;
				end
				ST_KDIV: begin
					if (ge)
						rem_q <= rem_sub;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						k_q     <= quo_nx[KW-1:0];
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					romv_q  <= rom_w[k_q];
					p1_q    <= maxv * m7;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!side_q) begin
						term_x_q <= term;
						side_q   <= 1'b1;
						state_q  <= ST_KLOAD;
					end else begin
						term_y_q <= term;
						side_q   <= 1'b0;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					sneg_q  <= sum[36];
					smag_q  <= sum[36] ? 35'(-sum) : 35'(sum);
					state_q <= ST_GLO;
				end
				ST_GLO: begin
					plo_q   <= smag_q[17:0] * cfg.rpm_gain;
					state_q <= ST_GHI;
				end
				ST_GHI: begin
					phi_q   <= smag_q[34:18] * cfg.rpm_gain;
					state_q <= ST_FLOAD;
				end
				ST_FLOAD: begin
					ovf_q <= fl_ov;
					rem_q <= fl_n;
					dsr_q <= 53'(cfg.stick_radius) << 38;
					quo_q <= '0;
					cnt_q <= 4'd15;
					// a quotient past 16 bits clamps anyway
					state_q <= fl_ov ? ST_FIN : ST_FDIV;
				end
				ST_FDIV: begin
					if (ge)
						rem_q <= rem_sub;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!side_q) begin
						left_q  <= fin_val;
						side_q  <= 1'b1;
						state_q <= ST_SUM;
					end else begin
						result_q <= '{left_target: left_q, right_target: fin_val,
						              motion_active: 1'b1};
						done_q   <= 1'b1;
						side_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/joystick_differential_drive_mix.sv =====
// Joystick to differential-drive mixer. A sample is taken when start is high and busy is low;
// the front end classifies it at once and parks it in a two-entry queue, so busy rises only
// when two samples wait behind the one being worked. The back end works one sample at a time
// on a shared 16-step restoring divider: a dead-zone or zero-radius sample is done from idle,
// one inside the stick circle runs index and final divides, one pulled onto the circle adds a
// divide and square root per axis (overflowing final divides are skipped). Each result shows on
// result for one cycle with done high; it cannot be held off, so it must be taken then.
module joystick_differential_drive_mix #(
	parameter int SINE_TABLE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  jddm_pkg::in_item_t                  sample,
	output logic                                done,
	output jddm_pkg::out_item_t                 result,
	input  logic                                cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jddm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jddm_pkg::*;

	cfg_t cfg_q;
	job_t front_job;
	job_t head;
	logic head_valid;
	logic pop;
	logic full;
	logic push;

	assign push = start && !busy;
	assign busy = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forward_max_speed <= 12'd960;
			cfg_q.reverse_max_speed <= 12'd384;
			cfg_q.turn_max_speed    <= 12'd282;
			cfg_q.rpm_gain          <= 16'd3840;
			cfg_q.dead_zone_radius  <= 7'd10;
			cfg_q.stick_radius      <= 7'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FWD:  cfg_q.forward_max_speed <= cfg_data[11:0];
				CFG_REV:  cfg_q.reverse_max_speed <= cfg_data[11:0];
				CFG_TURN: cfg_q.turn_max_speed    <= cfg_data[11:0];
				CFG_GAIN: cfg_q.rpm_gain          <= cfg_data;
				CFG_DEAD: cfg_q.dead_zone_radius  <= cfg_data[6:0];
				CFG_RAD:  cfg_q.stick_radius      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	jddm_front u_front (
		.cfg    (cfg_q),
		.sample (sample),
		.job    (front_job)
	);

	jddm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_job),
		.pop    (pop),
		.rdata  (head),
		.valid  (head_valid),
		.full   (full)
	);

	jddm_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result),
		.done       (done)
	);
endmodule

// ===== rtl/jddm_checker.sv =====
// port-level checker for the joystick mixer, bound to the top level
`include "joystick_differential_drive_mix_defines.svh"

module jddm_sva_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input jddm_pkg::out_item_t result
);
	import jddm_pkg::*;

	// queue only fills on an accepted beat
	`JDDM_ASSERT_NEXT(a_busy_after_start, !busy && !start, !busy, "busy rose without a beat")
	`JDDM_ASSERT_IMPLY(a_idle_zero, done && !result.motion_active, result.left_target == 16'sd0 && result.right_target == 16'sd0, "inactive result with nonzero target")
	`JDDM_ASSERT_IMPLY(a_left_range, done, result.left_target <= 16'sd25600 && result.left_target >= -16'sd25600, "left target out of range")
	`JDDM_ASSERT_IMPLY(a_right_range, done, result.right_target <= 16'sd25600 && result.right_target >= -16'sd25600, "right target out of range")
endmodule

bind joystick_differential_drive_mix jddm_sva_checker u_chk (.*);
